/* design/relocation_gap_filler_assert.svh */
// Assertion macros for the relocation gap filler.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef RELOCATION_GAP_FILLER_ASSERT_SVH
`define RELOCATION_GAP_FILLER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define RGF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define RGF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rgf_pkg.sv */
// Shared types and constants for the relocation gap filler.
// No dependencies; the symbol table and the top level refer to this package by scoped names.
package rgf_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_NO_SYM   = 3'd1,
    STATUS_BAD_TYPE = 3'd2,
    STATUS_OOB      = 3'd3,
    STATUS_FULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_CHECK,
    ST_WRITE,
    ST_RD_WAIT,
    ST_PUSH
  } state_e;

  // Largest size code that names a patch width (16 bytes).
  localparam logic [2:0] SIZE_CODE_MAX = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] name_key;
    logic [63:0] sym_value;
    logic [2:0]  sym_perms;
    logic [2:0]  gap_needs;
    logic        gap_relative;
    logic        gap_big_endian;
    logic [2:0]  gap_size_code;
    logic [15:0] byte_offset;
    logic [7:0]  byte_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  perm_faults;
    logic [7:0]  read_byte;
    logic [31:0] error_total;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
    logic [2:0]  flags;
  } sym_entry_t;

endpackage

/* design/rgf_sym_table.sv */
// Symbol table memory: key, value and permission flags per entry.
// One write port and one read port with registered read data; uses rgf_pkg.
module rgf_sym_table #(
  parameter int unsigned  Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  rgf_pkg::sym_entry_t     wdata_i,
  input  logic [AddrW-1:0]        raddr_i,
  output rgf_pkg::sym_entry_t     rdata_o
);

  rgf_pkg::sym_entry_t mem [Depth];
  rgf_pkg::sym_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/rgf_image_ram.sv */
// Byte-wide image store for the relocation gap filler.
// One write port and one read port with registered read data; no dependencies.
module rgf_image_ram #(
  parameter int unsigned  Depth = 65536,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/relocation_gap_filler.sv */
// Relocation gap filler: symbol table, image store and a patch sequencer.
// A fill runs a table scan, then writes the patch one image byte per cycle; other
// words take no scan and no patch step.
// The single table read port sets the scan rate: one entry compared per cycle.
// Reset clears the sequencer, the symbol count, the error count and image_size;
// table and image contents are undefined until written. Depends on rgf_pkg and on
// rgf_sym_table, rgf_image_ram and relocation_gap_filler_assert.svh.
`include "relocation_gap_filler_assert.svh"

module relocation_gap_filler #(
  parameter int unsigned SYMBOL_DEPTH = 256,
  parameter int unsigned IMAGE_DEPTH  = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel: carries image_size.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [16:0]        cfg_data_i,
  // Input words.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rgf_pkg::in_item_t  in_item_i,
  // Result words.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rgf_pkg::out_item_t out_item_o
);

  // Table index and count widths follow the table depth.
  localparam int unsigned SymIdxW = (SYMBOL_DEPTH > 1) ? $clog2(SYMBOL_DEPTH) : 1;
  localparam int unsigned SymCntW = $clog2(SYMBOL_DEPTH + 1);
  localparam logic [SymCntW-1:0] SymDepthW = SymCntW'(SYMBOL_DEPTH);
  localparam int unsigned ImgAddrW = (IMAGE_DEPTH > 1) ? $clog2(IMAGE_DEPTH) : 1;
  // The usable bound is the smaller of image_size and the store depth. image_size
  // never exceeds 17 bits, so capping the depth at that range leaves the minimum intact.
  localparam int unsigned DepthCap = (IMAGE_DEPTH > 131071) ? 131071 : IMAGE_DEPTH;
  localparam logic [16:0] DepthCapW = 17'(DepthCap);

  rgf_pkg::state_e    state_q, state_d;
  rgf_pkg::in_item_t  item_q;
  rgf_pkg::out_item_t out_q, out_d;
  rgf_pkg::status_e   status_q, status_d;
  logic               out_valid_q, out_valid_d;
  logic [16:0]        image_size_q;
  logic [SymCntW-1:0] sym_count_q, sym_count_d;
  logic [SymCntW-1:0] scan_idx_q, scan_idx_d;
  logic               pend_q, pend_d;
  logic [31:0]        err_count_q, err_count_d;
  logic [63:0]        value_q, value_d;
  logic [2:0]         flags_q, flags_d;
  logic [1:0]         faults_q, faults_d;
  logic [7:0]         rdbyte_q, rdbyte_d;
  logic [3:0]         size_m1_q, size_m1_d;
  logic [3:0]         k_q, k_d;

  logic                in_accept;
  logic [16:0]         bound;
  logic                off_oob;
  logic [4:0]          fill_size;
  logic                fill_oob;
  logic                scan_issue;
  logic [2:0]          miss;
  logic [3:0]          sig;
  logic [7:0]          fill_byte;
  logic [2:0]          err_inc;
  logic [32:0]         err_sum;
  logic [31:0]         err_next;

  logic                sym_we;
  rgf_pkg::sym_entry_t sym_wdata;
  rgf_pkg::sym_entry_t sym_rdata;
  logic                img_we;
  logic [16:0]         img_woff;
  logic [7:0]          img_wdata;
  logic [7:0]          img_rdata;

  // The block takes a new word only while the sequencer is idle. A finished result
  // may still sit in the output register; it is handed over in ST_PUSH.
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != rgf_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign bound    = (image_size_q < DepthCapW) ? image_size_q : DepthCapW;
  assign off_oob  = ({1'b0, item_q.byte_offset} >= bound);
  assign fill_size = 5'd1 << item_q.gap_size_code;
  assign fill_oob = (({2'b00, item_q.byte_offset} + {13'd0, fill_size}) > {1'b0, bound});

  // One table entry is read per cycle while the scan index is below the fill level;
  // the compare works on the entry read in the cycle before.
  assign scan_issue = (scan_idx_q < sym_count_q);

  assign miss = item_q.gap_needs & ~flags_q;

  // Byte significance of the patch byte being written; bytes above the eighth are zero.
  assign sig       = item_q.gap_big_endian ? (size_m1_q - k_q) : k_q;
  assign fill_byte = sig[3] ? 8'h00 : value_q[{sig[2:0], 3'b000} +: 8];

  // Saturating error count: permission faults plus one for any failing status.
  assign err_inc  = {1'b0, faults_q} + {2'b00, (status_q != rgf_pkg::STATUS_OK)};
  assign err_sum  = {1'b0, err_count_q} + {30'd0, err_inc};
  assign err_next = err_sum[32] ? 32'hFFFF_FFFF : err_sum[31:0];

  assign sym_wdata.key   = item_q.name_key;
  assign sym_wdata.value = item_q.sym_value;
  assign sym_wdata.flags = item_q.sym_perms;

  rgf_sym_table #(
    .Depth (SYMBOL_DEPTH)
  ) u_sym_table (
    .clk_i   (clk_i),
    .we_i    (sym_we),
    .waddr_i (sym_count_q[SymIdxW-1:0]),
    .wdata_i (sym_wdata),
    .raddr_i (scan_idx_q[SymIdxW-1:0]),
    .rdata_o (sym_rdata)
  );

  rgf_image_ram #(
    .Depth (IMAGE_DEPTH)
  ) u_image_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (ImgAddrW'(img_woff)),
    .wdata_i (img_wdata),
    .raddr_i (ImgAddrW'(item_q.byte_offset)),
    .rdata_o (img_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rgf_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      image_size_q <= '0;
      sym_count_q  <= '0;
      err_count_q  <= '0;
      scan_idx_q   <= '0;
      pend_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        image_size_q <= cfg_data_i;
      end
      sym_count_q <= sym_count_d;
      err_count_q <= err_count_d;
      scan_idx_q  <= scan_idx_d;
      pend_q      <= pend_d;
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item_i;
    end
    out_q     <= out_d;
    status_q  <= status_d;
    value_q   <= value_d;
    flags_q   <= flags_d;
    faults_q  <= faults_d;
    rdbyte_q  <= rdbyte_d;
    size_m1_q <= size_m1_d;
    k_q       <= k_d;
  end

  // Sequencer: decode the word; for a fill, scan the table, check and patch one byte per
  // cycle; a read waits for the image byte; then hand the result to the output register.
  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    sym_count_d = sym_count_q;
    scan_idx_d  = scan_idx_q;
    pend_d      = 1'b0;
    err_count_d = err_count_q;
    value_d     = value_q;
    flags_d     = flags_q;
    faults_d    = faults_q;
    rdbyte_d    = rdbyte_q;
    size_m1_d   = size_m1_q;
    k_d         = k_q;
    sym_we      = 1'b0;
    img_we      = 1'b0;
    img_woff    = {1'b0, item_q.byte_offset};
    img_wdata   = item_q.byte_data;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      rgf_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = rgf_pkg::ST_DISPATCH;
        end
      end

      rgf_pkg::ST_DISPATCH: begin
        status_d   = rgf_pkg::STATUS_OK;
        faults_d   = 2'd0;
        rdbyte_d   = 8'h00;
        scan_idx_d = '0;
        state_d    = rgf_pkg::ST_PUSH;
        unique case (item_q.op)
          rgf_pkg::OP_LOAD: begin
            if (sym_count_q >= SymDepthW) begin
              status_d = rgf_pkg::STATUS_FULL;
            end else begin
              sym_we      = 1'b1;
              sym_count_d = sym_count_q + 1'b1;
            end
          end
          rgf_pkg::OP_WRITE: begin
            if (off_oob) begin
              status_d = rgf_pkg::STATUS_OOB;
            end else begin
              img_we = 1'b1;
            end
          end
          rgf_pkg::OP_FILL: begin
            state_d = rgf_pkg::ST_SCAN;
          end
          rgf_pkg::OP_READ: begin
            if (off_oob) begin
              status_d = rgf_pkg::STATUS_OOB;
            end else begin
              state_d = rgf_pkg::ST_RD_WAIT;
            end
          end
          default: begin
            state_d = rgf_pkg::ST_PUSH;
          end
        endcase
      end

      rgf_pkg::ST_SCAN: begin
        if (pend_q && (sym_rdata.key == item_q.name_key)) begin
          value_d = sym_rdata.value;
          flags_d = sym_rdata.flags;
          state_d = rgf_pkg::ST_CHECK;
        end else if (scan_issue) begin
          pend_d     = 1'b1;
          scan_idx_d = scan_idx_q + 1'b1;
        end else if (!pend_q) begin
          status_d = rgf_pkg::STATUS_NO_SYM;
          state_d  = rgf_pkg::ST_PUSH;
        end
      end

      rgf_pkg::ST_CHECK: begin
        // Faults are reported even when the patch itself is refused.
        faults_d = {1'b0, miss[0]} + {1'b0, miss[1]} + {1'b0, miss[2]};
        if (item_q.gap_size_code > rgf_pkg::SIZE_CODE_MAX) begin
          status_d = rgf_pkg::STATUS_BAD_TYPE;
          state_d  = rgf_pkg::ST_PUSH;
        end else if (fill_oob) begin
          status_d = rgf_pkg::STATUS_OOB;
          state_d  = rgf_pkg::ST_PUSH;
        end else begin
          if (item_q.gap_relative) begin
            value_d = {48'd0, item_q.byte_offset} - value_q;
          end
          size_m1_d = 4'(fill_size - 5'd1);
          k_d       = 4'd0;
          state_d   = rgf_pkg::ST_WRITE;
        end
      end

      rgf_pkg::ST_WRITE: begin
        img_we    = 1'b1;
        img_woff  = {1'b0, item_q.byte_offset} + {13'd0, k_q};
        img_wdata = fill_byte;
        if (k_q == size_m1_q) begin
          status_d = rgf_pkg::STATUS_OK;
          state_d  = rgf_pkg::ST_PUSH;
        end else begin
          k_d = k_q + 4'd1;
        end
      end

      rgf_pkg::ST_RD_WAIT: begin
        rdbyte_d = img_rdata;
        state_d  = rgf_pkg::ST_PUSH;
      end

      rgf_pkg::ST_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.status      = status_q;
          out_d.perm_faults = faults_q;
          out_d.read_byte   = rdbyte_q;
          out_d.error_total = err_next;
          err_count_d       = err_next;
          state_d           = rgf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rgf_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Image writes, whether single bytes or patch bytes, stay inside the usable bound.
  `RGF_ASSERT_NOW(a_img_write_in_bound, img_we, img_woff < bound, "image write beyond bound")
  // A symbol is stored only while the table has room.
  `RGF_ASSERT_NOW(a_sym_write_room, sym_we, sym_count_q < SymDepthW, "symbol load into full table")
  // The error count never goes backwards outside reset.
  `RGF_ASSERT_NEXT(a_err_monotonic, 1'b1, err_count_q >= $past(err_count_q), "error count fell")
  // A new result appears only after the sequencer has been in its hand-over state.
  `RGF_ASSERT_NOW(a_result_from_push, $rose(out_valid_q), $past(state_q == rgf_pkg::ST_PUSH), "result without hand-over")

endmodule
